/* src/wsdf_pkg.sv */
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

	localparam int LEN_WIDTH   = 64;
	localparam int HDR_CNT_W   = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;

	localparam logic [3:0] OPC_BINARY = 4'd2;
	localparam logic [3:0] OPC_CLOSE  = 4'd8;
	localparam logic [3:0] OPC_PONG   = 4'd10;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	localparam logic [HDR_CNT_W-1:0] EXT_LAST_16 = HDR_CNT_W'(1);
	localparam logic [HDR_CNT_W-1:0] EXT_LAST_64 = HDR_CNT_W'(7);
	localparam logic [HDR_CNT_W-1:0] MASK_LAST   = HDR_CNT_W'(3);

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_RSV_BIT    = 3'd1,
		ST_RSV_OPCODE = 3'd2,
		ST_CTRL_LEN   = 3'd3,
		ST_HALTED     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_MASK    = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	// one classified result word, queued between parser and output stage
	typedef struct packed {
		logic       has_data;
		logic [7:0] data;
		logic [7:0] key;
		logic [3:0] opcode;
		logic       fin;
		logic       ccb;
		logic       eof;
		status_t    status;
	} wsdf_entry_t;

endpackage

/* src/wsdf_byte_if.sv */
// ----------------------------------------------------------------------------
// wsdf_byte_if
// Valid/ready channel carrying one received byte per word.
// ----------------------------------------------------------------------------
interface wsdf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

/* src/wsdf_result_if.sv */
// ----------------------------------------------------------------------------
// wsdf_result_if
// Valid/ready channel carrying one deframed result word.
// ----------------------------------------------------------------------------
interface wsdf_result_if;
	logic       valid;
	logic       ready;
	logic       has_data;
	logic [7:0] out_byte;
	logic [3:0] frame_opcode;
	logic       final_fragment;
	logic       close_code_byte;
	logic       end_of_frame;
	logic [2:0] status;

	modport source (
		output valid, output has_data, output out_byte, output frame_opcode,
		output final_fragment, output close_code_byte, output end_of_frame,
		output status, input ready
	);
	modport sink (
		input valid, input has_data, input out_byte, input frame_opcode,
		input final_fragment, input close_code_byte, input end_of_frame,
		input status, output ready
	);
endinterface

/* src/websocket_frame_deframer_unit.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// WebSocket receive-side frame deframer, one received byte per word.
// ----------------------------------------------------------------------------
// Takes one byte per clock on byte_in, header and payload alike, while the
// queue is not full. Header bytes give no result word unless they complete
// an empty frame or carry an error; each payload byte gives one unmasked,
// tagged result word. A result word reaches frame_out through a two-word
// queue and an output register, so the input keeps flowing while frame_out
// is stalled until the queue fills. The rate is set by the per-byte parser,
// whose slowest path is the 64-bit payload counter increment and compare.
// After a protocol error every further byte returns a halted status until
// arst_n is asserted.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit (
	input  logic          clk,
	input  logic          arst_n,
	wsdf_byte_if.sink     byte_in,
	wsdf_result_if.source frame_out
);
	import wsdf_pkg::*;

	logic        push;
	logic        pop;
	logic        q_full;
	logic        q_empty;
	wsdf_entry_t push_entry;
	wsdf_entry_t pop_entry;

	wsdf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.q_full  (q_full),
		.push    (push),
		.entry   (push_entry)
	);

	wsdf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.full     (q_full),
		.pop      (pop),
		.rd_entry (pop_entry),
		.empty    (q_empty)
	);

	wsdf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.entry     (pop_entry),
		.pop       (pop),
		.frame_out (frame_out)
	);

endmodule

/* src/wsdf_front.sv */
// ----------------------------------------------------------------------------
// wsdf_front
// Header parser and payload tracker: classifies each received byte and
// pushes a result word for payload bytes, empty frames and errors.
// ----------------------------------------------------------------------------
module wsdf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	wsdf_byte_if.sink             byte_in,
	input  logic                  q_full,
	output logic                  push,
	output wsdf_pkg::wsdf_entry_t entry
);
	import wsdf_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [HDR_CNT_W-1:0]   hdr_cnt_q, hdr_cnt_d;
	logic                   long_ext_q, long_ext_d;
	logic                   fin_q, fin_d;
	logic [3:0]             opc_q, opc_d;
	logic                   masked_q, masked_d;
	logic [LEN_WIDTH-1:0]   len_q, len_d;
	logic [LEN_WIDTH-1:0]   done_q, done_d;
	logic                   ovf_q, ovf_d;
	logic                   halted_q, halted_d;
	logic [7:0]             key_q [4];
	logic [7:0]             key_d [4];

	logic                   accept;
	logic [7:0]             b;
	logic                   rsv_bit;
	logic                   opc_ok;
	logic [6:0]             len_code;
	logic                   ext_code;
	logic                   ctrl_long;
	logic [LEN_WIDTH-1:0]   ext_shift;
	logic                   ext_ovf;
	logic                   ext_last;
	logic [LEN_WIDTH-1:0]   ext_len;
	logic                   mask_last;
	logic [LEN_WIDTH-1:0]   done_inc;
	logic                   last_byte;
	logic [7:0]             pay_key;

	assign byte_in.ready = !q_full;
	assign accept        = byte_in.valid && byte_in.ready;
	assign b             = byte_in.rx_byte;

	assign rsv_bit   = |b[6:4];
	assign opc_ok    = (b[3:0] <= OPC_BINARY) || ((b[3:0] >= OPC_CLOSE) && (b[3:0] <= OPC_PONG));
	assign len_code  = b[6:0];
	assign ext_code  = (len_code == LEN_CODE_16) || (len_code == LEN_CODE_64);
	assign ctrl_long = opc_q > OPC_BINARY;

	// extended length: shift in big-endian, sticky overflow past LEN_WIDTH
	assign ext_shift = {len_q[LEN_WIDTH-9:0], b};
	assign ext_ovf   = ovf_q || (|len_q[LEN_WIDTH-1 -: 8]);
	assign ext_last  = hdr_cnt_q == (long_ext_q ? EXT_LAST_64 : EXT_LAST_16);
	assign ext_len   = ext_ovf ? LEN_MAX : ext_shift;
	assign mask_last = hdr_cnt_q == MASK_LAST;

	assign done_inc  = done_q + 1'b1;
	assign last_byte = done_inc == len_q;
	assign pay_key   = masked_q ? key_q[done_q[1:0]] : 8'h00;

	always_comb begin
		phase_d    = phase_q;
		hdr_cnt_d  = hdr_cnt_q;
		long_ext_d = long_ext_q;
		fin_d      = fin_q;
		opc_d      = opc_q;
		masked_d   = masked_q;
		len_d      = len_q;
		done_d     = done_q;
		ovf_d      = ovf_q;
		halted_d   = halted_q;
		key_d      = key_q;
		if (accept && !halted_q) begin
			unique case (phase_q)
				PH_HDR0: begin
					if (rsv_bit || !opc_ok) begin
						halted_d = 1'b1;
					end else begin
						fin_d   = b[7];
						opc_d   = b[3:0];
						phase_d = PH_HDR1;
					end
				end
				PH_HDR1: begin
					masked_d = b[7];
					if (ext_code) begin
						if (ctrl_long) begin
							halted_d = 1'b1;
						end else begin
							long_ext_d = len_code == LEN_CODE_64;
							hdr_cnt_d  = '0;
							len_d      = '0;
							ovf_d      = 1'b0;
							phase_d    = PH_EXTLEN;
						end
					end else begin
						len_d = LEN_WIDTH'(len_code);
						if (b[7]) begin
							hdr_cnt_d = '0;
							phase_d   = PH_MASK;
						end else begin
							done_d  = '0;
							phase_d = (len_code == 7'd0) ? PH_HDR0 : PH_PAYLOAD;
						end
					end
				end
				PH_EXTLEN: begin
					len_d     = ext_shift;
					ovf_d     = ext_ovf;
					hdr_cnt_d = hdr_cnt_q + 1'b1;
					if (ext_last) begin
						len_d = ext_len;
						if (masked_q) begin
							hdr_cnt_d = '0;
							phase_d   = PH_MASK;
						end else begin
							done_d  = '0;
							phase_d = (ext_len == '0) ? PH_HDR0 : PH_PAYLOAD;
						end
					end
				end
				PH_MASK: begin
					key_d[hdr_cnt_q[1:0]] = b;
					hdr_cnt_d             = hdr_cnt_q + 1'b1;
					if (mask_last) begin
						done_d  = '0;
						phase_d = (len_q == '0) ? PH_HDR0 : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					done_d = done_inc;
					if (last_byte) begin
						phase_d = PH_HDR0;
					end
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase
		end
	end

	always_comb begin
		push  = 1'b0;
		entry = '0;
		if (accept) begin
			if (halted_q) begin
				push         = 1'b1;
				entry.status = ST_HALTED;
			end else begin
				unique case (phase_q)
					PH_HDR0: begin
						if (rsv_bit) begin
							push         = 1'b1;
							entry.status = ST_RSV_BIT;
						end else if (!opc_ok) begin
							push         = 1'b1;
							entry.status = ST_RSV_OPCODE;
						end
					end
					PH_HDR1: begin
						if (ext_code && ctrl_long) begin
							push         = 1'b1;
							entry.status = ST_CTRL_LEN;
						end else if (!ext_code && !b[7] && (len_code == 7'd0)) begin
							push         = 1'b1;
							entry.opcode = opc_q;
							entry.fin    = fin_q;
							entry.eof    = 1'b1;
						end
					end
					PH_EXTLEN: begin
						if (ext_last && !masked_q && (ext_len == '0)) begin
							push         = 1'b1;
							entry.opcode = opc_q;
							entry.fin    = fin_q;
							entry.eof    = 1'b1;
						end
					end
					PH_MASK: begin
						if (mask_last && (len_q == '0)) begin
							push         = 1'b1;
							entry.opcode = opc_q;
							entry.fin    = fin_q;
							entry.eof    = 1'b1;
						end
					end
					PH_PAYLOAD: begin
						push           = 1'b1;
						entry.has_data = 1'b1;
						entry.data     = b;
						entry.key      = pay_key;
						entry.opcode   = opc_q;
						entry.fin      = fin_q;
						entry.ccb      = (opc_q == OPC_CLOSE) && (done_q[LEN_WIDTH-1:1] == '0);
						entry.eof      = last_byte;
					end
					default: begin
						push = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR0;
			hdr_cnt_q  <= '0;
			long_ext_q <= 1'b0;
			fin_q      <= 1'b0;
			opc_q      <= '0;
			masked_q   <= 1'b0;
			len_q      <= '0;
			done_q     <= '0;
			ovf_q      <= 1'b0;
			halted_q   <= 1'b0;
			key_q      <= '{default: 8'h00};
		end else begin
			phase_q    <= phase_d;
			hdr_cnt_q  <= hdr_cnt_d;
			long_ext_q <= long_ext_d;
			fin_q      <= fin_d;
			opc_q      <= opc_d;
			masked_q   <= masked_d;
			len_q      <= len_d;
			done_q     <= done_d;
			ovf_q      <= ovf_d;
			halted_q   <= halted_d;
			key_q      <= key_d;
		end
	end

	a_data_only_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(push && entry.has_data) |-> (phase_q == PH_PAYLOAD && !halted_q))
		else $error("data word pushed outside payload");

	a_halted_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && halted_q) |-> (push && entry.status == ST_HALTED))
		else $error("halted parser dropped a word");

	a_halt_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(halted_q) |-> ($past(push) && $past(entry.status) != ST_OK))
		else $error("halt without error word");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (done_q < len_q))
		else $error("payload count overran frame length");

endmodule

/* src/wsdf_queue.sv */
// ----------------------------------------------------------------------------
// wsdf_queue
// Short FIFO of result words between the parser and the output stage.
// ----------------------------------------------------------------------------
module wsdf_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  wsdf_pkg::wsdf_entry_t wr_entry,
	output logic                  full,
	input  logic                  pop,
	output wsdf_pkg::wsdf_entry_t rd_entry,
	output logic                  empty
);
	import wsdf_pkg::*;

	wsdf_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign full     = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign empty    = cnt_q == '0;
	assign rd_entry = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* src/wsdf_back.sv */
// ----------------------------------------------------------------------------
// wsdf_back
// Output stage: unmasks the queued byte and holds the result word until
// the sink takes it.
// ----------------------------------------------------------------------------
module wsdf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  empty,
	input  wsdf_pkg::wsdf_entry_t entry,
	output logic                  pop,
	wsdf_result_if.source         frame_out
);
	import wsdf_pkg::*;

	logic       valid_q;
	logic       has_data_q;
	logic [7:0] out_byte_q;
	logic [3:0] opcode_q;
	logic       fin_q;
	logic       ccb_q;
	logic       eof_q;
	status_t    status_q;

	assign pop = !empty && (!valid_q || frame_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (frame_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			has_data_q <= entry.has_data;
			out_byte_q <= entry.data ^ entry.key;
			opcode_q   <= entry.opcode;
			fin_q      <= entry.fin;
			ccb_q      <= entry.ccb;
			eof_q      <= entry.eof;
			status_q   <= entry.status;
		end
	end

	assign frame_out.valid           = valid_q;
	assign frame_out.has_data        = has_data_q;
	assign frame_out.out_byte        = out_byte_q;
	assign frame_out.frame_opcode    = opcode_q;
	assign frame_out.final_fragment  = fin_q;
	assign frame_out.close_code_byte = ccb_q;
	assign frame_out.end_of_frame    = eof_q;
	assign frame_out.status          = status_q;

endmodule

/* tb/sv/tb_websocket_frame_deframer_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer_unit
// Self-checking bench for the WebSocket receive-side frame deframer.
// ----------------------------------------------------------------------------
// Feeds whole frames byte by byte: short directed frames first, then random
// frames of every legal opcode, masked and unmasked, with 7-, 16- and 64-bit
// length encodings. A predictor tracks the parser state per accepted word
// and queues the expected result words, which a scoreboard checks field by
// field as they leave the block. Both handshakes idle at random. The run
// closes with one protocol error, picked at random, and halted traffic.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer_unit;
	import wsdf_pkg::*;

	localparam int          CYCLE_LIMIT = 400000;
	localparam int          RAND_BYTES  = 1030;
	localparam logic [3:0]  OPC_CONT    = 4'd0;
	localparam logic [3:0]  OPC_TEXT    = 4'd1;
	localparam logic [3:0]  OPC_PING    = 4'd9;

	typedef enum int {
		ENC_7  = 0,
		ENC_16 = 1,
		ENC_64 = 2
	} len_enc_t;

	typedef enum int {
		ERR_RSV_BIT    = 0,
		ERR_RSV_OPCODE = 1,
		ERR_CTRL_LEN   = 2
	} err_kind_t;

	typedef struct packed {
		logic       has_data;
		logic [7:0] data;
		logic [3:0] opcode;
		logic       fin;
		logic       ccb;
		logic       eof;
		logic [2:0] status;
	} frame_word_t;

	class deframe_scoreboard;
		phase_t      phase;
		logic [3:0]  hdr_cnt;
		logic [3:0]  ext_needed;
		logic        fin;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] length;
		logic [63:0] done;
		logic [7:0]  key [4];
		logic        halted;
		frame_word_t expected_words [$];
		int          errors;
		int          words_checked;
		int          payload_words;
		int          eof_words;

		function new();
			phase         = PH_HDR0;
			hdr_cnt       = '0;
			ext_needed    = '0;
			fin           = 1'b0;
			opcode        = '0;
			masked        = 1'b0;
			length        = '0;
			done          = '0;
			foreach (key[i]) key[i] = '0;
			halted        = 1'b0;
			errors        = 0;
			words_checked = 0;
			payload_words = 0;
			eof_words     = 0;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		task report(string what);
			$display("[%0t] MISMATCH: %s", $realtime, what);
			errors++;
		endtask

		function bit header_complete(output frame_word_t w);
			w    = '0;
			done = '0;
			if (length == 64'd0) begin
				phase    = PH_HDR0;
				w.opcode = opcode;
				w.fin    = fin;
				w.eof    = 1'b1;
				w.status = ST_OK;
				return 1'b1;
			end
			phase = PH_PAYLOAD;
			return 1'b0;
		endfunction

		function bit length_complete(output frame_word_t w);
			w = '0;
			if (masked) begin
				phase   = PH_MASK;
				hdr_cnt = '0;
				return 1'b0;
			end
			return header_complete(w);
		endfunction

		function bit halt_with(logic [2:0] code, output frame_word_t w);
			w        = '0;
			halted   = 1'b1;
			w.status = code;
			return 1'b1;
		endfunction

		function bit step_byte(logic [7:0] b, output frame_word_t w);
			logic [6:0] code;
			logic [3:0] opc;
			logic [7:0] k;
			w = '0;
			if (halted) begin
				w.status = ST_HALTED;
				return 1'b1;
			end
			case (phase)
				PH_HDR1: begin
					code   = b[6:0];
					masked = b[7];
					if (code == LEN_CODE_16 || code == LEN_CODE_64) begin
						if (opcode > OPC_BINARY)
							return halt_with(ST_CTRL_LEN, w);
						ext_needed = (code == LEN_CODE_16) ? 4'd2 : 4'd8;
						hdr_cnt    = '0;
						length     = '0;
						phase      = PH_EXTLEN;
						return 1'b0;
					end
					length = 64'(code);
					return length_complete(w);
				end
				PH_EXTLEN: begin
					length  = {length[55:0], b};
					hdr_cnt = hdr_cnt + 4'd1;
					if (hdr_cnt < ext_needed)
						return 1'b0;
					if (length > 64'(LEN_MAX))
						length = 64'(LEN_MAX);
					return length_complete(w);
				end
				PH_MASK: begin
					key[hdr_cnt[1:0]] = b;
					hdr_cnt           = hdr_cnt + 4'd1;
					if (hdr_cnt < 4'd4)
						return 1'b0;
					return header_complete(w);
				end
				PH_PAYLOAD: begin
					k          = masked ? key[done[1:0]] : 8'h00;
					w.ccb      = (opcode == OPC_CLOSE && done < 64'd2);
					done       = done + 64'd1;
					w.eof      = (done >= length);
					if (w.eof)
						phase = PH_HDR0;
					w.has_data = 1'b1;
					w.data     = b ^ k;
					w.opcode   = opcode;
					w.fin      = fin;
					w.status   = ST_OK;
					return 1'b1;
				end
				default: begin
					opc = b[3:0];
					if (b[6:4] != 3'b000)
						return halt_with(ST_RSV_BIT, w);
					if (!(opc <= OPC_BINARY || (opc >= OPC_CLOSE && opc <= OPC_PONG)))
						return halt_with(ST_RSV_OPCODE, w);
					fin    = b[7];
					opcode = opc;
					phase  = PH_HDR1;
					return 1'b0;
				end
			endcase
		endfunction

		function void note_byte(logic [7:0] b);
			frame_word_t w;
			if (step_byte(b, w))
				expected_words.push_back(w);
		endfunction

		task check_word(frame_word_t got);
			frame_word_t exp_w;
			if (expected_words.size() == 0) begin
				report($sformatf("unexpected word %h", got));
				return;
			end
			exp_w = expected_words.pop_front();
			words_checked++;
			if (got.has_data)
				payload_words++;
			if (got.eof)
				eof_words++;
			if (got.has_data !== exp_w.has_data)
				report($sformatf("has_data %b, want %b", got.has_data, exp_w.has_data));
			if (got.data !== exp_w.data)
				report($sformatf("out_byte %h, want %h", got.data, exp_w.data));
			if (got.opcode !== exp_w.opcode)
				report($sformatf("frame_opcode %h, want %h", got.opcode, exp_w.opcode));
			if (got.fin !== exp_w.fin)
				report($sformatf("final_fragment %b, want %b", got.fin, exp_w.fin));
			if (got.ccb !== exp_w.ccb)
				report($sformatf("close_code_byte %b, want %b", got.ccb, exp_w.ccb));
			if (got.eof !== exp_w.eof)
				report($sformatf("end_of_frame %b, want %b", got.eof, exp_w.eof));
			if (got.status !== exp_w.status)
				report($sformatf("status %0d, want %0d", got.status, exp_w.status));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	wsdf_byte_if   byte_if ();
	wsdf_result_if res_if ();

	websocket_frame_deframer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_if),
		.frame_out (res_if)
	);

	deframe_scoreboard sb;
	bit                no_idle;
	int                cycle_cnt;
	int                bytes_sent;
	int                frames_sent;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_cnt);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// result side back-pressure
	initial begin
		int n;
		res_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				res_if.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	always @(posedge clk) begin : result_monitor
		frame_word_t got;
		if (arst_n && res_if.valid && res_if.ready) begin
			got.has_data = res_if.has_data;
			got.data     = res_if.out_byte;
			got.opcode   = res_if.frame_opcode;
			got.fin      = res_if.final_fragment;
			got.ccb      = res_if.close_code_byte;
			got.eof      = res_if.end_of_frame;
			got.status   = res_if.status;
			sb.check_word(got);
		end
	end

	task automatic send_byte(logic [7:0] b);
		int gap;
		byte_if.valid   <= 1'b1;
		byte_if.rx_byte <= b;
		do
			@(posedge clk);
		while (!byte_if.ready);
		sb.note_byte(b);
		bytes_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			byte_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		byte_if.valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_payload();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_frame(logic fin, logic [3:0] opc, logic masked, int len,
		len_enc_t enc);
		logic [63:0] len64;
		logic [6:0]  code;
		len64 = 64'(len);
		case (enc)
			ENC_16:  code = LEN_CODE_16;
			ENC_64:  code = LEN_CODE_64;
			default: code = len64[6:0];
		endcase
		send_byte({fin, 3'b000, opc});
		send_byte({masked, code});
		if (enc == ENC_16) begin
			send_byte(len64[15:8]);
			send_byte(len64[7:0]);
		end else if (enc == ENC_64) begin
			for (int i = 7; i >= 0; i--)
				send_byte(len64[i*8 +: 8]);
		end
		if (masked)
			repeat (4) send_byte(8'($urandom_range(0, 255)));
		for (int i = 0; i < len; i++)
			send_byte(pick_payload());
		frames_sent++;
	endtask

	task automatic send_random_frame();
		logic [3:0] opcodes [6];
		logic [3:0] opc;
		int         r;
		int         len;
		len_enc_t   enc;
		opcodes = '{OPC_CONT, OPC_TEXT, OPC_BINARY, OPC_CLOSE, OPC_PING, OPC_PONG};
		opc = opcodes[$urandom_range(0, 5)];
		r   = $urandom_range(0, 99);
		if (r < 70)
			len = $urandom_range(0, 8);
		else if (r < 92)
			len = $urandom_range(9, 40);
		else if (r < 95)
			len = 125;
		else
			len = $urandom_range(126, 300);
		if (opc > OPC_BINARY && len > 125)
			len = $urandom_range(0, 125);
		enc = ENC_7;
		if (len > 125)
			enc = ($urandom_range(0, 1) != 0) ? ENC_16 : ENC_64;
		else if (opc <= OPC_BINARY && $urandom_range(0, 9) == 0)
			enc = ($urandom_range(0, 1) != 0) ? ENC_16 : ENC_64;
		send_frame(1'($urandom_range(0, 1)), opc, ($urandom_range(0, 2) != 0), len, enc);
	endtask

	initial begin
		err_kind_t  err_kind;
		logic [3:0] opc;
		int         r;
		sb              = new();
		no_idle         = 1'b0;
		bytes_sent      = 0;
		frames_sent     = 0;
		arst_n          = 1'b0;
		byte_if.valid   <= 1'b0;
		byte_if.rx_byte <= 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty frames, masked and unmasked payload, close code, extended length encodings
		send_frame(1'b1, OPC_TEXT, 1'b0, 0, ENC_7);
		send_frame(1'b0, OPC_BINARY, 1'b1, 1, ENC_7);
		send_byte({1'b1, 3'b000, OPC_CLOSE});
		send_byte({1'b0, 7'd3});
		send_byte(8'h03);
		send_byte(8'hE8);
		send_byte(8'h41);
		frames_sent++;
		send_frame(1'b0, OPC_CONT, 1'b0, 0, ENC_16);
		send_frame(1'b0, OPC_PING, 1'b1, 0, ENC_7);
		send_frame(1'b1, OPC_PONG, 1'b0, 1, ENC_7);
		send_frame(1'b1, OPC_BINARY, 1'b0, 1, ENC_64);
		wait_drained();

		// random frames, one stretch without idling and a full drain if 120 frames are reached
		while (bytes_sent < RAND_BYTES) begin
			no_idle = (frames_sent >= 40 && frames_sent < 70);
			send_random_frame();
			if (frames_sent == 120)
				wait_drained();
		end
		no_idle = 1'b0;

		// close on a protocol error, then halted traffic
		err_kind = err_kind_t'($urandom_range(0, 2));
		case (err_kind)
			ERR_RSV_BIT:
				send_byte({1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)),
					4'($urandom_range(0, 15))});
			ERR_RSV_OPCODE: begin
				r   = $urandom_range(0, 9);
				opc = (r < 5) ? 4'(3 + r) : 4'(6 + r);
				send_byte({1'($urandom_range(0, 1)), 3'b000, opc});
			end
			default: begin
				send_byte({1'($urandom_range(0, 1)), 3'b000,
					4'($urandom_range(8, 10))});
				send_byte({1'($urandom_range(0, 1)),
					($urandom_range(0, 1) != 0) ? LEN_CODE_16 : LEN_CODE_64});
			end
		endcase
		repeat (12) send_byte(8'($urandom_range(0, 255)));
		wait_drained();
		repeat (8) @(posedge clk);

		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected words never arrived", sb.pending()));
		$display("Sent %0d bytes in %0d frames, closing error %s", bytes_sent,
			frames_sent, err_kind.name());
		$display("Checked %0d result words: %0d payload, %0d end of frame",
			sb.words_checked, sb.payload_words, sb.eof_words);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
